@@ hw/rtl/orle_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered record list engine package
// Request and result codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package orle_pkg;

	localparam int LIMIT = 16;
	localparam int REM_W = 5;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_REAR   = 2'd2,
		REQ_DUMP   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_APPENDED     = 3'd0,
		ST_FULL         = 3'd1,
		ST_DELETED      = 3'd2,
		ST_NOT_FOUND    = 3'd3,
		ST_REAR_REMOVED = 3'd4,
		ST_EMPTY        = 3'd5,
		ST_DUMP         = 3'd6,
		ST_NONE_REMOVED = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		RD_PTR  = 2'd0,
		RD_NEXT = 2'd1,
		RD_TAIL = 2'd2
	} rd_sel_t;

	typedef enum logic {
		WR_APPEND = 1'b0,
		WR_SHIFT  = 1'b1
	} wr_sel_t;

	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_RD   = 2'd1,
		SRC_HOLD = 2'd2
	} src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_APP,
		S_SRD,
		S_SCHK,
		S_MRD,
		S_MWR,
		S_DEL,
		S_NOTF,
		S_EMPTY,
		S_NONE,
		S_RRD,
		S_REMIT,
		S_DRD,
		S_DEMIT
	} state_t;

	typedef struct packed {
		logic    req_load;
		logic    ptr_clr;
		logic    ptr_inc;
		logic    rem_load_rear;
		logic    rem_load_dump;
		logic    rem_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    count_inc;
		logic    count_dec;
		logic    hold_load;
		logic    emit;
		status_t emit_status;
		src_t    emit_src;
		logic    emit_last;
	} cmd_t;

	typedef struct packed {
		req_t req_type;
		logic count_zero;
		logic full;
		logic match;
		logic ptr_last;
		logic ptr_last2;
		logic rcount_zero;
		logic rem_one;
		logic out_free;
	} stat_t;

endpackage

@@ hw/rtl/orle_dp.sv @@
// ----------------------------------------------------------------------------
// Ordered record list datapath
// Record memory with registered read, count and pointer registers, request
// holding registers and the result output register.
// ----------------------------------------------------------------------------
module orle_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  orle_pkg::cmd_t      cmd,
	output orle_pkg::stat_t     stat,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  cust_id,
	input  logic [7:0]          cust_age,
	input  logic [4:0]          remove_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic signed [31:0]  rec_id,
	output logic [7:0]          rec_age,
	output logic                last
);
	import orle_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [31:0] mem_id [CAPACITY];
	logic [7:0]  mem_age [CAPACITY];

	req_t        req_type_q;
	logic [31:0] req_id_q;
	logic [7:0]  req_age_q;
	logic [4:0]  req_cnt_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [REM_W-1:0] rem_q;
	logic [31:0] rd_id_q;
	logic [7:0]  rd_age_q;
	logic [31:0] hold_id_q;
	logic [7:0]  hold_age_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] rec_id_q;
	logic [7:0]  rec_age_q;
	logic        last_q;

	logic [CW:0]   ptr_p1;
	logic [CW:0]   ptr_p2;
	logic [CW-1:0] tail;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_id;
	logic [7:0]    wr_age;
	logic [REM_W-1:0] cnt_lim;
	logic [REM_W-1:0] rear_n;
	logic [31:0]   emit_id;
	logic [7:0]    emit_age;

	assign ptr_p1 = {1'b0, ptr_q} + (CW + 1)'(1);
	assign ptr_p2 = {1'b0, ptr_q} + (CW + 1)'(2);
	assign tail   = count_q - CW'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_PTR:  rd_addr = ptr_q[AW-1:0];
			RD_NEXT: rd_addr = ptr_p1[AW-1:0];
			RD_TAIL: rd_addr = tail[AW-1:0];
			default: rd_addr = ptr_q[AW-1:0];
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_APPEND: begin
				wr_addr = count_q[AW-1:0];
				wr_id   = req_id_q;
				wr_age  = req_age_q;
			end
			WR_SHIFT: begin
				wr_addr = ptr_q[AW-1:0];
				wr_id   = rd_id_q;
				wr_age  = rd_age_q;
			end
			default: begin
				wr_addr = count_q[AW-1:0];
				wr_id   = req_id_q;
				wr_age  = req_age_q;
			end
		endcase
	end

	always_comb begin
		if (32'(count_q) > LIMIT) begin
			cnt_lim = REM_W'(LIMIT);
		end else begin
			cnt_lim = REM_W'(count_q);
		end
		if (req_cnt_q < cnt_lim) begin
			rear_n = req_cnt_q;
		end else begin
			rear_n = cnt_lim;
		end
	end

	always_comb begin
		unique case (cmd.emit_src)
			SRC_RD: begin
				emit_id  = rd_id_q;
				emit_age = rd_age_q;
			end
			SRC_HOLD: begin
				emit_id  = hold_id_q;
				emit_age = hold_age_q;
			end
			default: begin
				emit_id  = '0;
				emit_age = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_id[wr_addr]  <= wr_id;
			mem_age[wr_addr] <= wr_age;
		end
		if (cmd.rd_en) begin
			rd_id_q  <= mem_id[rd_addr];
			rd_age_q <= mem_age[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_type_q <= req_t'(req_type);
			req_id_q   <= cust_id;
			req_age_q  <= cust_age;
			req_cnt_q  <= remove_count;
		end
		if (cmd.hold_load) begin
			hold_id_q  <= rd_id_q;
			hold_age_q <= rd_age_q;
		end
		if (cmd.emit) begin
			status_q  <= cmd.emit_status;
			rec_id_q  <= emit_id;
			rec_age_q <= emit_age;
			last_q    <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_p1[CW-1:0];
			end
			if (cmd.rem_load_rear) begin
				rem_q <= rear_n;
			end else if (cmd.rem_load_dump) begin
				rem_q <= cnt_lim;
			end else if (cmd.rem_dec) begin
				rem_q <= rem_q - REM_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.req_type    = req_type_q;
	assign stat.count_zero  = (count_q == '0);
	assign stat.full        = (32'(count_q) == CAPACITY);
	assign stat.match       = (rd_id_q == req_id_q);
	assign stat.ptr_last    = (ptr_p1 == {1'b0, count_q});
	assign stat.ptr_last2   = (ptr_p2 == {1'b0, count_q});
	assign stat.rcount_zero = (req_cnt_q == '0);
	assign stat.rem_one     = (rem_q == REM_W'(1));
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign rec_id    = rec_id_q;
	assign rec_age   = rec_age_q;
	assign last      = last_q;

endmodule

@@ hw/rtl/orle_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ordered record list controller
// Sequences each request through the datapath: search, compaction, rear
// removal and dump walk the memory one entry at a time.
// ----------------------------------------------------------------------------
module orle_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  orle_pkg::stat_t stat,
	output orle_pkg::cmd_t  cmd
);
	import orle_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.req_load = 1'b1;
					cmd.ptr_clr  = 1'b1;
					state_d      = S_DEC;
				end
			end
			S_DEC: begin
				unique case (stat.req_type)
					REQ_APPEND: state_d = S_APP;
					REQ_DELETE: state_d = stat.count_zero ? S_NOTF : S_SRD;
					REQ_REAR: begin
						if (stat.count_zero) begin
							state_d = S_EMPTY;
						end else if (stat.rcount_zero) begin
							state_d = S_NONE;
						end else begin
							cmd.rem_load_rear = 1'b1;
							state_d           = S_RRD;
						end
					end
					REQ_DUMP: begin
						if (stat.count_zero) begin
							state_d = S_EMPTY;
						end else begin
							cmd.rem_load_dump = 1'b1;
							state_d           = S_DRD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_APP: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_src  = SRC_ZERO;
					cmd.emit_last = 1'b1;
					if (stat.full) begin
						cmd.emit_status = ST_FULL;
					end else begin
						cmd.emit_status = ST_APPENDED;
						cmd.wr_en       = 1'b1;
						cmd.wr_sel      = WR_APPEND;
						cmd.count_inc   = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_SRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR;
				state_d    = S_SCHK;
			end
			S_SCHK: begin
				if (stat.match) begin
					cmd.hold_load = 1'b1;
					state_d       = stat.ptr_last ? S_DEL : S_MRD;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = stat.ptr_last ? S_NOTF : S_SRD;
				end
			end
			S_MRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NEXT;
				state_d    = S_MWR;
			end
			S_MWR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.ptr_inc = 1'b1;
				state_d     = stat.ptr_last2 ? S_DEL : S_MRD;
			end
			S_DEL: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_DELETED;
					cmd.emit_src    = SRC_HOLD;
					cmd.emit_last   = 1'b1;
					cmd.count_dec   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_NOTF: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_NOT_FOUND;
					cmd.emit_src    = SRC_ZERO;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_EMPTY;
					cmd.emit_src    = SRC_ZERO;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_NONE: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_NONE_REMOVED;
					cmd.emit_src    = SRC_ZERO;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_RRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_TAIL;
				state_d    = S_REMIT;
			end
			S_REMIT: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_REAR_REMOVED;
					cmd.emit_src    = SRC_RD;
					cmd.emit_last   = stat.rem_one;
					cmd.count_dec   = 1'b1;
					cmd.rem_dec     = 1'b1;
					state_d         = stat.rem_one ? S_IDLE : S_RRD;
				end
			end
			S_DRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR;
				state_d    = S_DEMIT;
			end
			S_DEMIT: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_DUMP;
					cmd.emit_src    = SRC_RD;
					cmd.emit_last   = stat.rem_one;
					cmd.ptr_inc     = 1'b1;
					cmd.rem_dec     = 1'b1;
					state_d         = stat.rem_one ? S_IDLE : S_DRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/ordered_record_list_engine.sv @@
// ----------------------------------------------------------------------------
// Ordered record list engine
// Bounded insertion-ordered list of id and age records with append, delete
// by id, remove from rear and dump requests.
// ----------------------------------------------------------------------------
// The list lives in a single-port memory with a registered read, and the
// controller takes one request at a time. An append, or a rear removal or
// dump that answers empty or none removed, passes through the decode state
// and then a single result state. A delete reads entries one by one up to
// the match, then reads and writes back each later record to close the gap;
// a rear removal or dump reads and delivers one record at a time. Any result
// state waits while the output register is still full and not taken; the
// next request is accepted once the last result of the current one sits in
// the output register. The memory needs no clearing after reset.
module ordered_record_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] cust_id,
	input  logic [7:0]         cust_age,
	input  logic [4:0]         remove_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] rec_id,
	output logic [7:0]         rec_age,
	output logic               last
);
	import orle_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	orle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	orle_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.cust_id      (cust_id),
		.cust_age     (cust_age),
		.remove_count (remove_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.rec_id       (rec_id),
		.rec_age      (rec_age),
		.last         (last)
	);

endmodule

@@ tb/ordered_record_list_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered record list engine testbench
// Sends append, delete, rear removal and dump requests with random stalls on
// both sides, and checks each result item against a scoreboard that keeps
// its own copy of the list and works out the answers to every request.
// ----------------------------------------------------------------------------
module ordered_record_list_engine_tb;
	import orle_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 40;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		status_t     st;
		logic [31:0] id;
		logic [7:0]  age;
		logic        last;
	} answer_t;

	class record_list_tracker;
		int          depth;
		logic [31:0] ids[];
		logic [7:0]  ages[];
		int          held;
		answer_t     awaited[$];
		int          errors;
		int          answers;
		int          requests[4];
		int          seen[8];
		int          longest;

		function new(int cap);
			depth = cap;
			ids = new[cap];
			ages = new[cap];
			held = 0;
			errors = 0;
			answers = 0;
			longest = 0;
			foreach (requests[i]) requests[i] = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void add(status_t st, logic [31:0] id, logic [7:0] age, logic last);
			answer_t a;
			a.st = st;
			a.id = id;
			a.age = age;
			a.last = last;
			awaited.push_back(a);
		endfunction

		function void note_request(req_t kind, logic [31:0] key, logic [7:0] age,
				logic [4:0] want);
			int n;
			int pos;
			n = 1;
			pos = -1;
			requests[kind]++;
			case (kind)
			REQ_APPEND: begin
				if (held < depth) begin
					ids[held] = key;
					ages[held] = age;
					held++;
					add(ST_APPENDED, '0, '0, 1'b1);
				end else begin
					add(ST_FULL, '0, '0, 1'b1);
				end
			end
			REQ_DELETE: begin
				for (int i = 0; i < held; i++)
					if (pos < 0 && ids[i] == key)
						pos = i;
				if (pos < 0) begin
					add(ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					add(ST_DELETED, ids[pos], ages[pos], 1'b1);
					for (int i = pos; i + 1 < held; i++) begin
						ids[i] = ids[i + 1];
						ages[i] = ages[i + 1];
					end
					held--;
				end
			end
			REQ_REAR: begin
				if (held == 0) begin
					add(ST_EMPTY, '0, '0, 1'b1);
				end else if (want == 0) begin
					add(ST_NONE_REMOVED, '0, '0, 1'b1);
				end else begin
					n = want;
					if (n > held) n = held;
					if (n > LIMIT) n = LIMIT;
					for (int i = 0; i < n; i++) begin
						held--;
						add(ST_REAR_REMOVED, ids[held], ages[held], i == n - 1);
					end
				end
			end
			default: begin
				if (held == 0) begin
					add(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					n = (held > LIMIT) ? LIMIT : held;
					for (int i = 0; i < n; i++)
						add(ST_DUMP, ids[i], ages[i], i == n - 1);
				end
			end
			endcase
			if (n > longest) longest = n;
		endfunction

		function void check_answer(logic [2:0] st, logic [31:0] id, logic [7:0] age,
				logic last);
			answer_t want;
			answers++;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result status %0d id %0d age %0d last %0b",
					st, $signed(id), age, last));
				return;
			end
			want = awaited.pop_front();
			seen[want.st]++;
			if (st !== want.st || id !== want.id || age !== want.age || last !== want.last)
				report($sformatf("got %0d/%0d/%0d/%0b, expected %0d/%0d/%0d/%0b",
					st, $signed(id), age, last,
					want.st, $signed(want.id), want.age, want.last));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         req_type;
	logic signed [31:0] cust_id;
	logic [7:0]         cust_age;
	logic [4:0]         remove_count;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic signed [31:0] rec_id;
	logic [7:0]         rec_age;
	logic               last;

	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 cycle_count = 0;
	record_list_tracker tracker;

	ordered_record_list_engine #(.CAPACITY(CAPACITY)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.cust_id(cust_id),
		.cust_age(cust_age),
		.remove_count(remove_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.rec_id(rec_id),
		.rec_age(rec_age),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_answer(status, rec_id, rec_age, last);
	end

	task automatic send_request(input req_t kind, input logic [31:0] key,
			input logic [7:0] age, input logic [4:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = kind;
		cust_id = key;
		cust_age = age;
		remove_count = want;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(kind, key, age, want);
		@(negedge clk);
	endtask

	task automatic drain();
		if (tracker.awaited.size() != 0) begin
			in_valid = 1'b0;
			while (tracker.awaited.size() != 0) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] random_id();
		if ($urandom_range(99) < 40)
			return 32'($urandom_range(7)) - 32'd4;
		return $urandom;
	endfunction

	function automatic logic [4:0] random_count();
		int r;
		r = $urandom_range(99);
		if (r < 20) return 5'd0;
		if (r < 65) return 5'($urandom_range(1, 3));
		if (r < 90) return 5'($urandom_range(4, 16));
		return 5'($urandom_range(17, 31));
	endfunction

	task automatic random_phase(input int count);
		int          sent;
		int          pick;
		logic [31:0] key;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				while (tracker.held < CAPACITY) begin
					send_request(REQ_APPEND, random_id(), 8'($urandom), 5'($urandom));
					sent++;
				end
				send_request(REQ_APPEND, random_id(), 8'($urandom), 5'($urandom));
				send_request(REQ_DUMP, random_id(), 8'($urandom), 5'($urandom));
				send_request(REQ_REAR, random_id(), 8'($urandom),
					5'($urandom_range(1, 31)));
				sent += 3;
			end else if (pick < 42) begin
				send_request(REQ_APPEND, random_id(), 8'($urandom), 5'($urandom));
				sent++;
			end else if (pick < 62) begin
				if (tracker.held > 0 && $urandom_range(99) < 65)
					key = tracker.ids[$urandom_range(tracker.held - 1)];
				else
					key = random_id();
				send_request(REQ_DELETE, key, 8'($urandom), 5'($urandom));
				sent++;
			end else if (pick < 80) begin
				send_request(REQ_REAR, random_id(), 8'($urandom), random_count());
				sent++;
			end else if (pick < 97) begin
				send_request(REQ_DUMP, random_id(), 8'($urandom), 5'($urandom));
				sent++;
			end else begin
				drain();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_APPEND;
		cust_id = '0;
		cust_age = '0;
		remove_count = '0;
		tracker = new(CAPACITY);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(REQ_DUMP, 32'd0, 8'd0, 5'd0);
		send_request(REQ_REAR, 32'd0, 8'd0, 5'd0);
		send_request(REQ_DELETE, 32'd0, 8'd0, 5'd0);
		send_request(REQ_APPEND, 32'h7FFF_FFFF, 8'hFF, 5'd0);
		send_request(REQ_APPEND, 32'h8000_0000, 8'h00, 5'd31);
		send_request(REQ_APPEND, 32'hFFFF_FFFF, 8'h55, 5'd16);
		send_request(REQ_APPEND, 32'd0, 8'hAA, 5'd0);
		send_request(REQ_APPEND, 32'd5, 8'd1, 5'd0);
		send_request(REQ_APPEND, 32'd5, 8'd2, 5'd0);
		send_request(REQ_DUMP, 32'd0, 8'd0, 5'd0);
		send_request(REQ_DELETE, 32'd5, 8'd0, 5'd0);
		send_request(REQ_DELETE, 32'h1234_5678, 8'd0, 5'd0);
		send_request(REQ_REAR, 32'd0, 8'd0, 5'd0);
		send_request(REQ_REAR, 32'd0, 8'd0, 5'd1);
		send_request(REQ_DELETE, 32'h8000_0000, 8'd0, 5'd0);
		send_request(REQ_DUMP, 32'd0, 8'd0, 5'd0);
		send_request(REQ_REAR, 32'd0, 8'd0, 5'd31);
		send_request(REQ_DUMP, 32'd0, 8'd0, 5'd0);
		send_request(REQ_DELETE, 32'hFFFF_FFFF, 8'd0, 5'd0);
		drain();

		send_idle_pct = 19;
		recv_idle_pct = 82;
		random_phase(PHASE_ITEMS);
		drain();
		send_idle_pct = 82;
		recv_idle_pct = 19;
		random_phase(PHASE_ITEMS);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(PHASE_ITEMS);
		in_valid = 1'b0;
		drain();
		repeat (SETTLE) @(negedge clk);
		if (tracker.awaited.size() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.awaited.size()));

		$display("Sent %0d appends, %0d deletes, %0d rear removals and %0d dumps; %0d results.",
			tracker.requests[REQ_APPEND], tracker.requests[REQ_DELETE],
			tracker.requests[REQ_REAR], tracker.requests[REQ_DUMP], tracker.answers);
		$display("Saw full %0d, not found %0d, empty %0d, none removed %0d; longest answer %0d.",
			tracker.seen[ST_FULL], tracker.seen[ST_NOT_FOUND], tracker.seen[ST_EMPTY],
			tracker.seen[ST_NONE_REMOVED], tracker.longest);
		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ ordered_record_list_engine.f @@
hw/rtl/orle_pkg.sv
hw/rtl/orle_dp.sv
hw/rtl/orle_ctrl.sv
hw/rtl/ordered_record_list_engine.sv
tb/ordered_record_list_engine_tb.sv
